// File: sv/bdeq_pkg.sv
// types and constants shared by the bounded double-ended queue files
`timescale 1ns / 1ps
package bdeq_pkg;

  localparam int CAP_W   = 11;
  localparam int WORD_W  = 32;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // operation codes; codes above OP_QUERY behave as a query
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;

  // configuration register index
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RDF  = 4'b0010,
    S_RDR  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage

// File: sv/bdeq_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module bdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bounded_double_ended_queue_top.sv
// bounded double-ended queue of signed words kept in a ring buffer ram
`timescale 1ns / 1ps
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  input   | start, busy, in_word                    | taken when start & !busy
//  result  | out_valid, out_word                     | one-cycle strobe, no back-pressure
//  config  | psel, penable, pwrite, paddr, pwdata,   | apb write on access cycle,
//          | prdata, pready                          | pready tied high
//
// each word runs through the accept cycle, which does the push write and the head and
// count update, then the ram read port fetches the front entry, then the rear entry,
// then the result is strobed; busy is high from the front fetch to the strobe, so no
// new word is taken before the result. one ram read port serves both fetches. reset
// clears head, count and capacity (capacity back to 1024); the ram is not cleared,
// only live entries are reported. the receiver cannot stall, so no result is held back.
module bounded_double_ended_queue_top #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  bdeq_pkg::in_word_t                in_word,
  output logic                              out_valid,
  output bdeq_pkg::out_word_t               out_word,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdeq_pkg::CFG_AW-1:0]       paddr,
  input  logic [bdeq_pkg::CFG_DW-1:0]       pwdata,
  output logic [bdeq_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready
);

  import bdeq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // wrap a sum of index and count back into the ring
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
    logic [CNT_W:0] w;
    w = (s >= (CNT_W+1)'(DEPTH)) ? s - (CNT_W+1)'(DEPTH) : s;
    return w[IDX_W-1:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic               ok_r, ok_nxt;
  logic [WORD_W-1:0]  front_r;

  logic               accept;
  logic               cfg_wr;
  logic [CMP_W-1:0]   eff_cap;
  logic               full;
  logic               empty;

  // ram ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = CFG_DW'(cap_r);
    end
  end

  // capacity saturates at the ring depth
  assign eff_cap = (CMP_W'(cap_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_r);
  assign full    = CMP_W'(count_r) >= eff_cap;
  assign empty   = (count_r == '0);

  // ---------------------------------------------------------------- operation
  // head and count move at the accept edge; a push writes the ram at that same edge
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ok_nxt    = ok_r;
    ram_we    = 1'b0;
    ram_waddr = head_r;
    if (accept) begin
      ok_nxt = 1'b1;
      case (in_word.operation)
        OP_PUSH_FRONT: begin
          if (full) begin
            ok_nxt = 1'b0;
          end else begin
            head_nxt  = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
            count_nxt = count_r + 1'b1;
            ram_we    = 1'b1;
            ram_waddr = head_nxt;
          end
        end
        OP_PUSH_REAR: begin
          if (full) begin
            ok_nxt = 1'b0;
          end else begin
            count_nxt = count_r + 1'b1;
            ram_we    = 1'b1;
            ram_waddr = wrap_idx((CNT_W+1)'(head_r) + (CNT_W+1)'(count_r));
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            ok_nxt = 1'b0;
          end else begin
            head_nxt  = wrap_idx((CNT_W+1)'(head_r) + (CNT_W+1)'(1));
            count_nxt = count_r - 1'b1;
          end
        end
        OP_POP_REAR: begin
          if (empty) begin
            ok_nxt = 1'b0;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          // query and spare codes leave the state alone
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_RDF;
      S_RDF:   state_nxt = S_RDR;
      S_RDR:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // front address while fetching the front, rear address otherwise
  always_comb begin
    if (state_r == S_RDF) begin
      ram_raddr = head_r;
    end else begin
      ram_raddr = wrap_idx((CNT_W+1)'(head_r) + (CNT_W+1)'(count_r) - (CNT_W+1)'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // front entry arrives from the ram while the rear read is issued
  always_ff @(posedge clk) begin
    if (state_r == S_RDR) begin
      front_r <= ram_rdata;
    end
  end

  bdeq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_word.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- result
  // rear entry sits on the ram output during the strobe cycle
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    out_word.ok          = ok_r;
    out_word.front_value = empty ? '1 : front_r;
    out_word.rear_value  = empty ? '1 : ram_rdata;
    out_word.is_empty    = empty;
    out_word.is_full     = full;
  end

  // ---------------------------------------------------------------- checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted word");

  a_write_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (accept && !full))
    else $error("ram written outside an accepted push with room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CMP_W'(count_r) <= CMP_W'(DEPTH)))
    else $error("entry count beyond ring depth");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.is_empty) |-> (out_word.front_value == '1 &&
                                          out_word.rear_value == '1))
    else $error("empty result does not report all ones");

endmodule
